// File: rtl/dtp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared constants for the display test pattern pixel generator: colors,
// pattern geometry, register indexes and reciprocal constants.
// ----------------------------------------------------------------------------
package dtp_pkg;

    localparam int unsigned COORD_W  = 11;
    localparam int unsigned MARKER_W = 12;
    localparam int unsigned PIXEL_W  = 24;
    localparam int unsigned CFG_W    = 12;
    localparam int unsigned INDEX_W  = 1;

    typedef logic [PIXEL_W-1:0] color_t;
    typedef logic [COORD_W-1:0] coord_t;

    localparam logic [INDEX_W-1:0] REG_MARKER_POSITION = 1'd0;
    localparam logic [INDEX_W-1:0] REG_OUTPUT_FORMAT   = 1'd1;

    localparam color_t COLOR_RED     = 24'hff2020;
    localparam color_t COLOR_GREEN   = 24'h20ff20;
    localparam color_t COLOR_BLUE    = 24'h2040ff;
    localparam color_t COLOR_WHITE   = 24'hffffff;
    localparam color_t COLOR_BLACK   = 24'h000000;
    localparam color_t COLOR_MAGENTA = 24'hff00ff;
    localparam color_t COLOR_CYAN    = 24'h00ffff;
    localparam color_t COLOR_YELLOW  = 24'hffff00;

    localparam coord_t BORDER_PX  = 11'd8;
    localparam coord_t GRID_LINE  = 11'd3;
    localparam coord_t CHECK_X0   = 11'd240;
    localparam coord_t CHECK_X1   = 11'd400;
    localparam coord_t CHECK_Y0   = 11'd180;
    localparam coord_t CHECK_Y1   = 11'd300;
    localparam coord_t BAR_MARGIN = 11'd32;
    localparam logic [MARKER_W-1:0] BAR_WIDTH = 12'd16;

    // reciprocal of 5 for values below 1024, quotient is product >> 14
    localparam logic [11:0] RECIP5      = 12'd3277;
    localparam int unsigned RECIP5_SH   = 14;
    // reciprocal of 15 for values below 512, quotient is product >> 16
    localparam logic [12:0] RECIP15     = 13'd4370;
    localparam int unsigned RECIP15_SH  = 16;

endpackage

`default_nettype wire

// File: rtl/display_test_pattern_pixel.sv
`default_nettype none
// path: an accepted request is held in the input register, then its result in the result register
// throughput: one pixel per cycle while pixel_stall is low, set by the input and result register pair
// a stalled result holds while one more request waits in the input register
// reset: asynchronous active-low, clears both valid flags, marker off, rgb888
// ----------------------------------------------------------------------------
// display_test_pattern_pixel
// Returns one pixel of a fixed display test pattern per coordinate request:
// quadrant colors, white border, black grid, central checkerboard and a
// movable yellow marker bar, in rgb888 or packed rgb565.
// ----------------------------------------------------------------------------
module display_test_pattern_pixel #(
    parameter int unsigned WIDTH  = 640,
    parameter int unsigned HEIGHT = 480
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          coord_valid,
    output logic                         coord_stall,
    input  wire  [dtp_pkg::COORD_W-1:0]  column,
    input  wire  [dtp_pkg::COORD_W-1:0]  row,
    output logic                         pixel_valid,
    input  wire                          pixel_stall,
    output logic [dtp_pkg::PIXEL_W-1:0]  pixel_value,
    input  wire                          write_enable,
    input  wire  [dtp_pkg::INDEX_W-1:0]  write_index,
    input  wire  [dtp_pkg::CFG_W-1:0]    write_data
);
    import dtp_pkg::*;

    localparam logic [11:0] HALF_X       = 12'(WIDTH / 2);
    localparam logic [11:0] HALF_Y       = 12'(HEIGHT / 2);
    localparam logic [11:0] BORDER_RIGHT = 12'(WIDTH - 8);
    localparam logic [11:0] BORDER_BOT   = 12'(HEIGHT - 8);
    localparam logic [11:0] BAR_BOTTOM   = 12'(HEIGHT - 32);

    logic [MARKER_W-1:0] marker_position_reg;
    logic                output_format_reg;

    logic   stage_valid_reg;
    logic   stage_valid_next;
    coord_t column_reg;
    coord_t row_reg;
    logic   pixel_valid_reg;
    logic   pixel_valid_next;
    color_t pixel_value_reg;
    color_t pixel_value_next;

    logic   advance;
    logic   accept;

    logic [18:0] prod_x80;
    logic [4:0]  quot_x80;
    coord_t      rem_x80;
    logic [21:0] prod_y60;
    logic [5:0]  quot_y60;
    coord_t      rem_y60;
    logic [21:0] prod_x10;
    logic [21:0] prod_y10;
    logic [11:0] cx;
    logic [11:0] cy;
    logic        on_border;
    logic        on_grid;
    logic        in_checker;
    logic        on_marker;
    logic [1:0]  quadrant;
    color_t      color;

    assign advance     = !pixel_valid_reg || !pixel_stall;
    assign coord_stall = stage_valid_reg && !advance;
    assign accept      = coord_valid && !coord_stall;
    assign pixel_valid = pixel_valid_reg;
    assign pixel_value = pixel_value_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_position_reg <= '1;
            output_format_reg   <= 1'b0;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                REG_MARKER_POSITION: marker_position_reg <= write_data[MARKER_W-1:0];
                REG_OUTPUT_FORMAT:   output_format_reg   <= write_data[0];
                default:             ;
            endcase
        end
    end

    // pattern evaluation
    always_comb
    begin
        cx = {1'b0, column_reg};
        cy = {1'b0, row_reg};

        prod_x80 = {12'd0, column_reg[10:4]} * {7'd0, RECIP5};
        quot_x80 = prod_x80[RECIP5_SH +: 5];
        rem_x80  = column_reg - ({quot_x80, 6'd0} + {2'd0, quot_x80, 4'd0});

        prod_y60 = {13'd0, row_reg[10:2]} * {9'd0, RECIP15};
        quot_y60 = prod_y60[RECIP15_SH +: 6];
        rem_y60  = row_reg - ({quot_y60[4:0], 6'd0} - {3'd0, quot_y60, 2'd0});

        prod_x10 = {12'd0, column_reg[10:1]} * {10'd0, RECIP5};
        prod_y10 = {12'd0, row_reg[10:1]} * {10'd0, RECIP5};

        quadrant  = {cy >= HALF_Y, cx >= HALF_X};
        on_border = (column_reg < BORDER_PX) || (cx >= BORDER_RIGHT) ||
                    (row_reg < BORDER_PX) || (cy >= BORDER_BOT);
        on_grid   = (rem_x80 < GRID_LINE) || (rem_y60 < GRID_LINE);
        in_checker = (column_reg >= CHECK_X0) && (column_reg < CHECK_X1) &&
                     (row_reg >= CHECK_Y0) && (row_reg < CHECK_Y1);
        on_marker = !marker_position_reg[MARKER_W-1] &&
                    (cx >= marker_position_reg) &&
                    (cx < marker_position_reg + BAR_WIDTH) &&
                    (row_reg >= BAR_MARGIN) && (cy < BAR_BOTTOM);

        unique case (quadrant)
            2'd0:    color = COLOR_RED;
            2'd1:    color = COLOR_GREEN;
            2'd2:    color = COLOR_BLUE;
            default: color = COLOR_WHITE;
        endcase

        if (on_border)
        begin
            color = COLOR_WHITE;
        end
        else if (on_grid)
        begin
            color = COLOR_BLACK;
        end

        if (in_checker)
        begin
            color = (prod_x10[RECIP5_SH] ^ prod_y10[RECIP5_SH]) ? COLOR_MAGENTA
                                                                : COLOR_CYAN;
        end

        if (on_marker)
        begin
            color = COLOR_YELLOW;
        end

        if (output_format_reg)
        begin
            pixel_value_next = {8'd0, color[23:19], color[15:10], color[7:3]};
        end
        else
        begin
            pixel_value_next = color;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
        pixel_valid_next = advance ? stage_valid_reg : pixel_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            pixel_valid_reg <= pixel_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            column_reg <= column;
            row_reg    <= row;
        end
        if (advance && stage_valid_reg)
        begin
            pixel_value_reg <= pixel_value_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dtp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks for the test pattern pixel generator: request count,
// held results and the zero upper byte of rgb565 results.
// ----------------------------------------------------------------------------
module dtp_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          coord_valid,
    input wire                          coord_stall,
    input wire                          pixel_valid,
    input wire                          pixel_stall,
    input wire [dtp_pkg::PIXEL_W-1:0]   pixel_value,
    input wire                          write_enable,
    input wire [dtp_pkg::INDEX_W-1:0]   write_index,
    input wire [dtp_pkg::CFG_W-1:0]     write_data
);
    import dtp_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       format_reg;
    logic       format_known_reg;
    logic       in_take;
    logic       out_take;

    assign in_take  = coord_valid && !coord_stall;
    assign out_take = pixel_valid && !pixel_stall;

    always_comb
    begin
        pending_next = pending_reg + {1'b0, in_take} - {1'b0, out_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg      <= 2'd0;
            format_reg       <= 1'b0;
            format_known_reg <= 1'b1;
        end
        else
        begin
            pending_reg <= pending_next;
            if (write_enable && write_index == REG_OUTPUT_FORMAT)
            begin
                format_reg       <= write_data[0];
                format_known_reg <= (pending_reg == 2'd0);
            end
        end
    end

    // at most the input and the result register hold requests
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two requests in flight");

    // no result appears without an accepted request
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd0 |-> !pixel_valid)
        else $error("result without request");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_value))
        else $error("stalled result changed");

    // rgb565 results keep the upper byte clear
    a_rgb565_upper: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && format_reg && format_known_reg |-> pixel_value[23:16] == 8'd0)
        else $error("rgb565 result with upper byte set");

endmodule

bind display_test_pattern_pixel dtp_checker u_dtp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .coord_valid  (coord_valid),
    .coord_stall  (coord_stall),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_value  (pixel_value),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
);

`default_nettype wire

// File: verif/display_test_pattern_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// display_test_pattern_pixel_checker
// Watches the coordinate, pixel and register ports of the pattern generator.
// Each accepted coordinate request is turned into the pixel color the
// pattern should show under the current marker and format settings, and
// that color is queued. Each accepted pixel is compared with the oldest
// queued color.
// ----------------------------------------------------------------------------
module display_test_pattern_pixel_checker #(
    parameter int WIDTH  = 640,
    parameter int HEIGHT = 480
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          coord_valid,
    input  wire                          coord_stall,
    input  wire  [dtp_pkg::COORD_W-1:0]  column,
    input  wire  [dtp_pkg::COORD_W-1:0]  row,
    input  wire                          pixel_valid,
    input  wire                          pixel_stall,
    input  wire  [dtp_pkg::PIXEL_W-1:0]  pixel_value,
    input  wire                          write_enable,
    input  wire  [dtp_pkg::INDEX_W-1:0]  write_index,
    input  wire  [dtp_pkg::CFG_W-1:0]    write_data,
    output int                           pixel_errors,
    output int                           pixels_pending
);

    localparam logic [23:0] SHADE_RED     = 24'hff2020;
    localparam logic [23:0] SHADE_GREEN   = 24'h20ff20;
    localparam logic [23:0] SHADE_BLUE    = 24'h2040ff;
    localparam logic [23:0] SHADE_WHITE   = 24'hffffff;
    localparam logic [23:0] SHADE_BLACK   = 24'h000000;
    localparam logic [23:0] SHADE_MAGENTA = 24'hff00ff;
    localparam logic [23:0] SHADE_CYAN    = 24'h00ffff;
    localparam logic [23:0] SHADE_YELLOW  = 24'hffff00;
    localparam int          MAX_REPORTS   = 10;

    int          marker_pos;
    bit          rgb565_mode;
    logic [23:0] expected_pixels[$];

    function automatic logic [23:0] predict_color(input int cx, input int cy,
                                                  input int marker, input bit pack);
        logic [23:0] px;
        if (cy >= HEIGHT / 2)
            px = (cx >= WIDTH / 2) ? SHADE_WHITE : SHADE_BLUE;
        else
            px = (cx >= WIDTH / 2) ? SHADE_GREEN : SHADE_RED;
        if (cx < 8 || cx >= WIDTH - 8 || cy < 8 || cy >= HEIGHT - 8)
            px = SHADE_WHITE;
        else if (cx % 80 < 3 || cy % 60 < 3)
            px = SHADE_BLACK;
        if (cx >= 240 && cx < 400 && cy >= 180 && cy < 300)
            px = (((cx / 10) ^ (cy / 10)) & 1) ? SHADE_MAGENTA : SHADE_CYAN;
        if (marker >= 0 && cx >= marker && cx < marker + 16 && cy >= 32 && cy < HEIGHT - 32)
            px = SHADE_YELLOW;
        if (pack)
            px = {8'h00, px[23:19], px[15:10], px[7:3]};
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] want;
        if (!rst_n)
        begin
            marker_pos <= -1;
            rgb565_mode <= 1'b0;
            expected_pixels.delete();
            pixel_errors = 0;
            pixels_pending <= 0;
        end
        else
        begin
            if (coord_valid && !coord_stall)
                expected_pixels.push_back(predict_color(int'(column), int'(row),
                                                        marker_pos, rgb565_mode));
            if (pixel_valid && !pixel_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (pixel_errors < MAX_REPORTS)
                        $display("unexpected pixel %06h with no request pending", pixel_value);
                    pixel_errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_value !== want)
                    begin
                        if (pixel_errors < MAX_REPORTS)
                            $display("pixel mismatch: expected %06h got %06h", want, pixel_value);
                        pixel_errors++;
                    end
                end
            end
            if (write_enable)
            begin
                case (write_index)
                    dtp_pkg::REG_MARKER_POSITION: marker_pos <= $signed(write_data);
                    dtp_pkg::REG_OUTPUT_FORMAT:   rgb565_mode <= write_data[0];
                    default: ;
                endcase
            end
            pixels_pending <= expected_pixels.size();
        end
    end

endmodule

// File: verif/display_test_pattern_pixel_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// display_test_pattern_pixel_tb
// Drives coordinate requests into the test pattern generator: a directed
// set covering quadrants, border, grid lines, checkerboard, marker bar
// edges and coordinates past the frame, then random coordinates under
// several marker and format settings. Both ports idle at random but in the last
// three phases; the checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module display_test_pattern_pixel_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 9;
    localparam int PHASE_ITEMS    = 100;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         coord_valid  = 1'b0;
    logic [dtp_pkg::COORD_W-1:0]  column       = '0;
    logic [dtp_pkg::COORD_W-1:0]  row          = '0;
    logic                         pixel_stall  = 1'b0;
    logic                         write_enable = 1'b0;
    logic [dtp_pkg::INDEX_W-1:0]  write_index  = '0;
    logic [dtp_pkg::CFG_W-1:0]    write_data   = '0;
    wire                          coord_stall;
    wire                          pixel_valid;
    wire  [dtp_pkg::PIXEL_W-1:0]  pixel_value;

    int pixel_errors;
    int pixels_pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int marker_now    = -1;
    int quiet_cycles  = 0;

    display_test_pattern_pixel dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .coord_valid  (coord_valid),
        .coord_stall  (coord_stall),
        .column       (column),
        .row          (row),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_value  (pixel_value),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    display_test_pattern_pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .coord_valid    (coord_valid),
        .coord_stall    (coord_stall),
        .column         (column),
        .row            (row),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .pixel_value    (pixel_value),
        .write_enable   (write_enable),
        .write_index    (write_index),
        .write_data     (write_data),
        .pixel_errors   (pixel_errors),
        .pixels_pending (pixels_pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        pixel_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((coord_valid && !coord_stall) || (pixel_valid && !pixel_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_coord(input int c, input int r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            coord_valid <= 1'b0;
            @(posedge clk);
        end
        coord_valid <= 1'b1;
        column <= dtp_pkg::coord_t'(c);
        row <= dtp_pkg::coord_t'(r);
        @(posedge clk);
        while (coord_stall)
            @(posedge clk);
    endtask

    task automatic set_config(input int marker, input bit rgb565);
        write_enable <= 1'b1;
        write_index <= dtp_pkg::REG_MARKER_POSITION;
        write_data <= marker[dtp_pkg::CFG_W-1:0];
        @(posedge clk);
        write_index <= dtp_pkg::REG_OUTPUT_FORMAT;
        write_data <= dtp_pkg::CFG_W'(rgb565);
        @(posedge clk);
        write_enable <= 1'b0;
        marker_now = marker;
    endtask

    // stop requests, wait for every queued pixel, then idle before the next phase
    task automatic drain();
        coord_valid <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int plain_col[18]  = '{0, 2047, 100, 500, 100, 500, 7, 632, 100, 82, 100,
                               240, 250, 399, 400, 319, 320, 1024};
        int plain_row[18]  = '{0, 2047, 100, 100, 400, 400, 100, 100, 472, 100, 62,
                               180, 180, 299, 300, 239, 240, 1024};
        int marker_col[7]  = '{624, 639, 640, 623, 624, 630, 2047};
        int marker_row[7]  = '{32, 31, 100, 100, 447, 448, 250};
        int phase_marker[PHASE_COUNT];
        int c;
        int r;
        int sel;

        phase_marker = '{-1, 2047, 0, -2048, 300, 632, 0, 0, 2032};
        phase_marker[6] = $urandom_range(0, 639);
        phase_marker[7] = int'($urandom_range(0, 4095)) - 2048;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 45;
        foreach (plain_col[i])
            send_coord(plain_col[i], plain_row[i]);
        drain();
        set_config(624, 1'b1);
        foreach (marker_col[i])
            send_coord(marker_col[i], marker_row[i]);
        drain();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase / 3)
                0: begin send_idle_pct = 29; recv_idle_pct = 45; end
                1: begin send_idle_pct = 45; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            set_config(phase_marker[phase], phase[0]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = $urandom_range(9);
                c = $urandom_range(0, 639);
                r = $urandom_range(0, 479);
                if (sel == 4)
                begin
                    c = $urandom_range(235, 404);
                    r = $urandom_range(175, 304);
                end
                else if ((sel == 5 || sel == 6) && marker_now >= 0)
                begin
                    c = marker_now - 4 + $urandom_range(0, 23);
                    if (c < 0)
                        c = 0;
                    if (c > 2047)
                        c = 2047;
                    r = $urandom_range(28, 451);
                end
                else if (sel == 7)
                begin
                    c = $urandom_range(1) ? $urandom_range(0, 11) : $urandom_range(628, 643);
                    r = $urandom_range(1) ? $urandom_range(0, 11) : $urandom_range(468, 483);
                end
                else if (sel >= 8)
                begin
                    c = $urandom_range(0, 2047);
                    r = $urandom_range(0, 2047);
                end
                send_coord(c, r);
            end
            drain();
        end

        if (pixel_errors == 0 && pixels_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
